FILE: src/smm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the small matrix multiplier.
// No dependencies; imported by small_matrix_multiply.
package smm_pkg;

    // Configuration register fields and layout.
    localparam int unsigned CFG_W      = 4;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned OUT_IDX_W  = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd6;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    // Input function codes.
    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    // Bookkeeping that travels alongside each multiply-accumulate.
    typedef struct packed {
        logic                 first;
        logic                 last_k;
        logic                 last_elem;
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
    } mac_tag_t;

endpackage

FILE: src/small_matrix_multiply.sv
`timescale 1ns / 1ps
// Operation: a compute runs one MAC per cycle while the result channel does not stall;
// each product element is shown once the sum of its inner_dim products is complete.
// Input: a load writes its element when it is accepted; a compute holds s_ready low until it
// has issued every A and B read pair, and longer while a stalled result channel holds it.
// Reset (synchronous, aresetn low): dimensions return to 6, all valid flags clear;
// the A and B element memories are not cleared and hold undefined data until loaded.
module small_matrix_multiply
    import smm_pkg::*;
#(
    parameter int unsigned MAX_DIM    = 8,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // APB-style configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,

    // Input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic [2:0]                   s_row,
    input  logic [2:0]                   s_col,
    input  logic signed [DATA_WIDTH-1:0] s_value,

    // Result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [OUT_IDX_W-1:0]         m_out_row,
    output logic [OUT_IDX_W-1:0]         m_out_col,
    output logic signed [DATA_WIDTH-1:0] m_out_value,
    output logic                         m_saturated,
    output logic                         m_last
);

    // Memory and datapath geometry. Each operand is split into an unsigned low half and a
    // signed high half so that every multiplier stays near 17 x 17 bits at the default width.
    localparam int unsigned IDX_W     = $clog2(MAX_DIM);
    localparam int unsigned MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
    localparam int unsigned LD_W      = 8;
    localparam int unsigned H_W       = (DATA_WIDTH + 1) / 2;
    localparam int unsigned HI_W      = DATA_WIDTH - H_W;
    localparam int unsigned PP_W      = 2 * H_W + 2;
    // A sum of up to 16 full products never overflows this width.
    localparam int unsigned ACC_W     = 2 * DATA_WIDTH + 4;

    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] rows_a_reg;
    logic [CFG_W-1:0] inner_dim_reg;
    logic [CFG_W-1:0] cols_b_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= CFG_RESET;
            inner_dim_reg <= CFG_RESET;
            cols_b_reg    <= CFG_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_ROWS_A:    rows_a_reg    <= pwdata[CFG_W-1:0];
                REG_INNER_DIM: inner_dim_reg <= pwdata[CFG_W-1:0];
                REG_COLS_B:    cols_b_reg    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS_A:    prdata = {{(APB_DATA_W-CFG_W){1'b0}}, rows_a_reg};
            REG_INNER_DIM: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, inner_dim_reg};
            REG_COLS_B:    prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cols_b_reg};
            default:       prdata = '0;
        endcase
    end

    // A dimension of zero behaves as one and anything above MAX_DIM as MAX_DIM.
    // The sequencer keeps the last index (dimension minus one).
    function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] d);
        priority if (d == '0) begin
            return '0;
        end else if ({1'b0, d} > 5'(MAX_DIM)) begin
            return IDX_W'(MAX_DIM - 1);
        end else begin
            return IDX_W'(d - 4'd1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control. The whole datapath stalls while the output register
    // holds a product element that has not been taken.
    // ------------------------------------------------------------------
    logic pipe_en;
    logic out_valid_reg;

    assign pipe_en = !out_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Sequencer: walks row i, column j and inner index k, issuing one read of
    // A[i][k] and B[k][j] per enabled cycle.
    // ------------------------------------------------------------------
    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] nr_last_reg, nc_last_reg, nk_last_reg;
    logic             in_fire;
    logic             compute_fire;
    logic             issue;

    // New transactions are taken only once every read of a running product has been issued,
    // so loads can never overwrite an element that is still to be read.
    assign s_ready      = (state_reg == ST_IDLE);
    assign in_fire      = s_valid && s_ready;
    assign compute_fire = in_fire && (s_func == FUNC_COMPUTE);
    assign issue        = (state_reg == ST_RUN) && pipe_en;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (compute_fire) begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN: begin
                if (pipe_en) begin
                    if (k_reg != nk_last_reg) begin
                        k_next = k_reg + 1'b1;
                    end else begin
                        k_next = '0;
                        if (j_reg != nc_last_reg) begin
                            j_next = j_reg + 1'b1;
                        end else begin
                            j_next = '0;
                            if (i_reg != nr_last_reg) begin
                                i_next = i_reg + 1'b1;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Dimensions are captured when the compute transaction is accepted.
    always_ff @(posedge aclk) begin
        if (compute_fire) begin
            nr_last_reg <= dim_last(rows_a_reg);
            nk_last_reg <= dim_last(inner_dim_reg);
            nc_last_reg <= dim_last(cols_b_reg);
        end
    end

    mac_tag_t tag0;

    always_comb begin
        tag0.first     = (k_reg == '0);
        tag0.last_k    = (k_reg == nk_last_reg);
        tag0.last_elem = (k_reg == nk_last_reg) && (j_reg == nc_last_reg)
                         && (i_reg == nr_last_reg);
        tag0.row       = OUT_IDX_W'(i_reg);
        tag0.col       = OUT_IDX_W'(j_reg);
    end

    // ------------------------------------------------------------------
    // Element memories: one write port for loads, one registered read port.
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] mem_a [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] mem_b [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b;
    logic [LD_W-1:0]       ld_full;
    logic [ADDR_W-1:0]     ld_addr;
    logic                  ld_in_range;
    logic                  ld_a_we, ld_b_we;

    assign rd_addr_a = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
    assign rd_addr_b = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);

    // Loads whose row or column falls outside the array are dropped.
    assign ld_full     = LD_W'(s_row) * LD_W'(MAX_DIM) + LD_W'(s_col);
    assign ld_addr     = ADDR_W'(ld_full);
    assign ld_in_range = (5'(s_row) < 5'(MAX_DIM)) && (5'(s_col) < 5'(MAX_DIM));
    assign ld_a_we     = in_fire && ld_in_range && (s_func == FUNC_LOAD_A);
    assign ld_b_we     = in_fire && ld_in_range && (s_func == FUNC_LOAD_B);

    always_ff @(posedge aclk) begin
        if (ld_a_we) begin
            mem_a[ld_addr] <= s_value;
        end
        if (issue) begin
            rd_a_reg <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_b_we) begin
            mem_b[ld_addr] <= s_value;
        end
        if (issue) begin
            rd_b_reg <= mem_b[rd_addr_b];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: four partial products of the half-split operands.
    // ------------------------------------------------------------------
    logic                   v1_reg, v2_reg, v3_reg, done4_reg;
    mac_tag_t               tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic signed [H_W:0]    a_lo, b_lo;
    logic signed [HI_W-1:0] a_hi, b_hi;
    logic signed [PP_W-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic signed [ACC_W-1:0] prod_next, prod_reg;
    logic signed [ACC_W-1:0] acc_next, acc_reg;

    assign a_lo = {1'b0, rd_a_reg[H_W-1:0]};
    assign b_lo = {1'b0, rd_b_reg[H_W-1:0]};
    assign a_hi = rd_a_reg[DATA_WIDTH-1:H_W];
    assign b_hi = rd_b_reg[DATA_WIDTH-1:H_W];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pp_ll_reg <= PP_W'(a_lo) * PP_W'(b_lo);
            pp_lh_reg <= PP_W'(a_lo) * PP_W'(b_hi);
            pp_hl_reg <= PP_W'(a_hi) * PP_W'(b_lo);
            pp_hh_reg <= PP_W'(a_hi) * PP_W'(b_hi);
        end
    end

    // Stage 3: recombine the partial products into the full signed product.
    assign prod_next = (ACC_W'(pp_hh_reg) <<< (2 * H_W))
                     + ((ACC_W'(pp_hl_reg) + ACC_W'(pp_lh_reg)) <<< H_W)
                     + ACC_W'(pp_ll_reg);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod_reg <= prod_next;
        end
    end

    // Stage 4: accumulate; the first product of each element restarts the sum.
    assign acc_next = tag3_reg.first ? prod_reg : (acc_reg + prod_reg);

    always_ff @(posedge aclk) begin
        if (pipe_en && v3_reg) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            tag1_reg <= tag0;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            done4_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg    <= (state_reg == ST_RUN);
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            done4_reg <= v3_reg && tag3_reg.last_k;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: drop the fraction bits (rounding toward minus infinity),
    // saturate, and load the output register.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]         acc_shifted;
    logic [ACC_W-DATA_WIDTH:0]       shifted_top;
    logic                            fits;
    logic signed [DATA_WIDTH-1:0]    final_value;

    assign acc_shifted = acc_reg >>> FRAC_BITS;
    assign shifted_top = acc_shifted[ACC_W-1:DATA_WIDTH-1];
    assign fits        = (&shifted_top) || !(|shifted_top);
    assign final_value = fits ? acc_shifted[DATA_WIDTH-1:0]
                              : (acc_reg[ACC_W-1] ? SAT_MIN : SAT_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= done4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && done4_reg) begin
            m_out_row   <= tag4_reg.row;
            m_out_col   <= tag4_reg.col;
            m_out_value <= final_value;
            m_saturated <= !fits;
            m_last      <= tag4_reg.last_elem;
        end
    end

    assign m_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_compute_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        compute_fire |=> (state_reg == ST_RUN))
        else $error("compute transaction did not start the sequencer");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (k_reg <= nk_last_reg) && (j_reg <= nc_last_reg)
                                  && (i_reg <= nr_last_reg))
        else $error("sequencer index beyond captured dimension");

    a_no_load_while_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> !(ld_a_we || ld_b_we))
        else $error("memory written while product reads are pending");

    a_acc_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(acc_reg))
        else $error("accumulator changed while output stalled");

    a_done_has_last_k: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && v3_reg && tag3_reg.last_k) |=> done4_reg)
        else $error("finished element was not passed to the output stage");

endmodule
